FILE: rtl/eprot_pkg.sv
package eprot_pkg;

  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int PHASE_W      = 13;
  localparam int ANGLE_W      = 16;
  localparam int TURN_W       = 15;
  localparam int PHASE_SHIFT  = 7;
  localparam int PHASE_DIV    = 45;
  localparam int COORD_W      = 24;
  localparam int SC_STAGES    = 6;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  // Taylor series of sin(x), x in Q30, rounded and clipped to frac bits
  function automatic logic [31:0] quarter_entry(input logic [63:0] x, input int frac);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    logic signed [63:0] half;
    logic signed [63:0] one;
    int                 sh;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k < 14; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    sh   = 30 - frac;
    half = 64'sd1 <<< (sh - 1);
    one  = 64'sd1 <<< frac;
    v    = (sum + half) >>> sh;
    if (v < 0) begin
      v = 0;
    end
    if (v > one) begin
      v = one;
    end
    return v[31:0];
  endfunction

endpackage

FILE: rtl/eprot_sincos.sv
module eprot_sincos #(
  parameter int SINE_TABLE_ENTRIES = 256,
  parameter int TRIG_FRAC_BITS     = 15
) (
  input  logic                                 clk,
  input  logic [eprot_pkg::SC_STAGES-1:0]      adv,
  input  logic signed [eprot_pkg::ANGLE_W-1:0] angle,
  output logic signed [TRIG_FRAC_BITS+1:0]     sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0]     cos_val
);
  import eprot_pkg::*;

  localparam int N   = SINE_TABLE_ENTRIES;
  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int IW  = $clog2(N + 1);
  localparam int PRW = PHASE_W + IW;
  localparam int QW  = PRW - PHASE_SHIFT;
  localparam int RS  = QW + 8;
  localparam int RMW = RS - 4;
  localparam logic [RMW-1:0] RECIP = RMW'((64'd1 << RS) / PHASE_DIV);

  logic [TRIG_FRAC_BITS:0] qtab [N+1];

  for (genvar i = 0; i <= N; i++) begin : g_tab
    localparam logic [63:0] XARG = 64'(i) * HALF_PI_Q30 / 64'(N);
    localparam logic [31:0] QVAL = quarter_entry(XARG, TRIG_FRAC_BITS);
    assign qtab[i] = QVAL[TRIG_FRAC_BITS:0];
  end

  logic [TURN_W-1:0]  u_r, u_nxt;
  logic [1:0]         quad_b_r, quad_c_r, quad_d_r, quad_e_r, quad_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PRW-1:0]     prod_r;
  logic [QW-1:0]      qv_r;
  logic [IW-1:0]      est_r, est_nxt, idx_r, idx_nxt;
  logic [QW+RMW-1:0]  est_full;
  logic [QW-1:0]      rem;
  logic signed [TW-1:0] sin_r, cos_r, sin_nxt, cos_nxt;

  always_comb begin
    logic signed [ANGLE_W:0] ae;
    logic signed [ANGLE_W:0] ft;
    logic signed [ANGLE_W:0] r;
    ae = {angle[ANGLE_W-1], angle};
    ft = $signed((ANGLE_W + 1)'(FULL_TURN));
    if (ae < -ft) begin
      r = ae + ft + ft;
    end else if (ae < 0) begin
      r = ae + ft;
    end else if (ae >= ft) begin
      r = ae - ft;
    end else begin
      r = ae;
    end
    u_nxt = r[TURN_W-1:0];
  end

  always_comb begin
    if (u_r < TURN_W'(QUARTER_TURN)) begin
      quad_nxt  = 2'd0;
      phase_nxt = u_r[PHASE_W-1:0];
    end else if (u_r < TURN_W'(2 * QUARTER_TURN)) begin
      quad_nxt  = 2'd1;
      phase_nxt = PHASE_W'(u_r - TURN_W'(QUARTER_TURN));
    end else if (u_r < TURN_W'(3 * QUARTER_TURN)) begin
      quad_nxt  = 2'd2;
      phase_nxt = PHASE_W'(u_r - TURN_W'(2 * QUARTER_TURN));
    end else begin
      quad_nxt  = 2'd3;
      phase_nxt = PHASE_W'(u_r - TURN_W'(3 * QUARTER_TURN));
    end
  end

  assign est_full = (QW + RMW)'(prod_r[PRW-1:PHASE_SHIFT]) * (QW + RMW)'(RECIP);
  assign est_nxt  = IW'(est_full >> RS);
  assign rem      = qv_r - QW'(est_r) * QW'(PHASE_DIV);
  assign idx_nxt  = (rem >= QW'(PHASE_DIV)) ? est_r + 1'b1 : est_r;

  always_comb begin
    logic [TRIG_FRAC_BITS:0] ta;
    logic [TRIG_FRAC_BITS:0] tb;
    logic signed [TW-1:0]    sa;
    logic signed [TW-1:0]    sb;
    logic [1:0]              qc;
    ta = qtab[idx_r];
    tb = qtab[IW'(N) - idx_r];
    sa = $signed({1'b0, ta});
    sb = $signed({1'b0, tb});
    qc = quad_e_r + 2'd1;
    sin_nxt = quad_e_r[0] ? sb : sa;
    if (quad_e_r[1]) begin
      sin_nxt = -sin_nxt;
    end
    cos_nxt = qc[0] ? sb : sa;
    if (qc[1]) begin
      cos_nxt = -cos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      u_r <= u_nxt;
    end
    if (adv[1]) begin
      quad_b_r <= quad_nxt;
      phase_r  <= phase_nxt;
    end
    if (adv[2]) begin
      quad_c_r <= quad_b_r;
      prod_r   <= PRW'(phase_r) * PRW'(N);
    end
    if (adv[3]) begin
      quad_d_r <= quad_c_r;
      qv_r     <= prod_r[PRW-1:PHASE_SHIFT];
      est_r    <= est_nxt;
    end
    if (adv[4]) begin
      quad_e_r <= quad_d_r;
      idx_r    <= idx_nxt;
    end
    if (adv[5]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

FILE: rtl/euler_point_rotation_3d_unit.sv
// Throughput: one word per cycle while out_tready does not stall the pipeline; every stage carries its own valid bit.
// Backpressure from out_tready stops only the stages that are full.
// Reset (rst_n low, synchronous) clears the valid bits; data registers keep
// their contents. The sine table is constant logic, so no fill time follows.
module euler_point_rotation_3d_unit #(
  parameter int SINE_TABLE_ENTRIES = 256,
  parameter int TRIG_FRAC_BITS     = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x, point_y, point_z, angle_x, angle_y, angle_z
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rotated_x, rotated_y, rotated_z
  output logic [71:0]  out_tdata,
  // saturated
  output logic [0:0]   out_tuser
);
  import eprot_pkg::*;

  localparam int TF  = TRIG_FRAC_BITS;
  localparam int TW  = TF + 2;
  localparam int PTW = 2 * TW;
  localparam int MW  = TW + 1;
  localparam int PW  = COORD_W + MW;
  localparam int AW  = PW + 2;
  localparam int NS  = SC_STAGES + 7;
  localparam int PTS = SC_STAGES + 4;

  localparam int T_SXSY = 0;
  localparam int T_CXSY = 1;
  localparam int T_CYCZ = 2;
  localparam int T_CYSZ = 3;
  localparam int T_SXCY = 4;
  localparam int T_CXCY = 5;
  localparam int T_CXSZ = 6;
  localparam int T_CXCZ = 7;
  localparam int T_SXSZ = 8;
  localparam int T_SXCZ = 9;

  localparam logic signed [PTW-1:0] HALF_T = PTW'(1) << (TF - 1);
  localparam logic signed [AW-1:0]  HALF_A = AW'(1) << (TF - 1);
  localparam logic signed [TW-1:0]  TRIG_ONE = TW'(1) << TF;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  logic [3*COORD_W-1:0] pt_r [PTS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pt_r[0] <= in_tdata[3*COORD_W-1:0];
    end
    for (int k = 1; k < PTS; k++) begin
      if (en[k]) begin
        pt_r[k] <= pt_r[k-1];
      end
    end
  end

  logic signed [TW-1:0] sin_v [3];
  logic signed [TW-1:0] cos_v [3];

  for (genvar j = 0; j < 3; j++) begin : g_axis
    eprot_sincos #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
      .TRIG_FRAC_BITS    (TRIG_FRAC_BITS)
    ) u_sincos (
      .clk    (clk),
      .adv    (en[SC_STAGES-1:0]),
      .angle  ($signed(in_tdata[3*COORD_W+j*ANGLE_W +: ANGLE_W])),
      .sin_val(sin_v[j]),
      .cos_val(cos_v[j])
    );
  end

  function automatic logic signed [TW-1:0] rnd_t(input logic signed [PTW-1:0] p);
    logic signed [PTW-1:0] w;
    w = (p + HALF_T) >>> TF;
    return w[TW-1:0];
  endfunction

  logic signed [PTW-1:0] tp_r [10];
  logic signed [TW-1:0]  tr_r [10];
  logic signed [TW-1:0]  tr8_r [10];
  logic signed [TW-1:0]  s1_6_r, s2_6_r, c2_6_r, s1_7_r, s2_7_r, c2_7_r, s1_8_r;
  logic signed [PTW-1:0] q8_r [4];
  logic signed [MW-1:0]  m_r [9];
  logic signed [MW-1:0]  m_nxt [9];
  logic signed [PW-1:0]  pm_r [9];
  logic signed [AW-1:0]  rw_r [3];
  logic signed [AW-1:0]  rw_nxt [3];
  logic signed [COORD_W-1:0] rot_r [3];
  logic signed [COORD_W-1:0] rot_nxt [3];
  logic                  sat_r, sat_nxt;

  always_comb begin
    logic signed [MW-1:0] a;
    logic signed [MW-1:0] b;
    a = rnd_t(q8_r[0]);
    b = tr8_r[T_CXSZ];
    m_nxt[3] = a - b;
    a = rnd_t(q8_r[1]);
    b = tr8_r[T_CXCZ];
    m_nxt[4] = a + b;
    a = rnd_t(q8_r[2]);
    b = tr8_r[T_SXSZ];
    m_nxt[6] = a + b;
    a = rnd_t(q8_r[3]);
    b = tr8_r[T_SXCZ];
    m_nxt[7] = a - b;
    m_nxt[0] = tr8_r[T_CYCZ];
    m_nxt[1] = tr8_r[T_CYSZ];
    a = s1_8_r;
    m_nxt[2] = -a;
    m_nxt[5] = tr8_r[T_SXCY];
    m_nxt[8] = tr8_r[T_CXCY];
  end

  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] t0;
    logic signed [AW-1:0] t1;
    logic signed [AW-1:0] t2;
    for (int r = 0; r < 3; r++) begin
      t0 = pm_r[3*r];
      t1 = pm_r[3*r+1];
      t2 = pm_r[3*r+2];
      acc = t0 + t1 + t2 + HALF_A;
      rw_nxt[r] = acc >>> TF;
    end
  end

  always_comb begin
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = COORD_MAX;
    lo = COORD_MIN;
    sat_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (rw_r[r] > hi) begin
        rot_nxt[r] = COORD_MAX;
        sat_nxt    = 1'b1;
      end else if (rw_r[r] < lo) begin
        rot_nxt[r] = COORD_MIN;
        sat_nxt    = 1'b1;
      end else begin
        rot_nxt[r] = rw_r[r][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SC_STAGES]) begin
      tp_r[T_SXSY] <= sin_v[0] * sin_v[1];
      tp_r[T_CXSY] <= cos_v[0] * sin_v[1];
      tp_r[T_CYCZ] <= cos_v[1] * cos_v[2];
      tp_r[T_CYSZ] <= cos_v[1] * sin_v[2];
      tp_r[T_SXCY] <= sin_v[0] * cos_v[1];
      tp_r[T_CXCY] <= cos_v[0] * cos_v[1];
      tp_r[T_CXSZ] <= cos_v[0] * sin_v[2];
      tp_r[T_CXCZ] <= cos_v[0] * cos_v[2];
      tp_r[T_SXSZ] <= sin_v[0] * sin_v[2];
      tp_r[T_SXCZ] <= sin_v[0] * cos_v[2];
      s1_6_r <= sin_v[1];
      s2_6_r <= sin_v[2];
      c2_6_r <= cos_v[2];
    end
    if (en[SC_STAGES+1]) begin
      for (int i = 0; i < 10; i++) begin
        tr_r[i] <= rnd_t(tp_r[i]);
      end
      s1_7_r <= s1_6_r;
      s2_7_r <= s2_6_r;
      c2_7_r <= c2_6_r;
    end
    if (en[SC_STAGES+2]) begin
      q8_r[0] <= tr_r[T_SXSY] * c2_7_r;
      q8_r[1] <= tr_r[T_SXSY] * s2_7_r;
      q8_r[2] <= tr_r[T_CXSY] * c2_7_r;
      q8_r[3] <= tr_r[T_CXSY] * s2_7_r;
      tr8_r   <= tr_r;
      s1_8_r  <= s1_7_r;
    end
    if (en[SC_STAGES+3]) begin
      m_r <= m_nxt;
    end
    if (en[SC_STAGES+4]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pm_r[3*r+c] <= $signed(pt_r[PTS-1][c*COORD_W +: COORD_W]) * m_r[3*r+c];
        end
      end
    end
    if (en[SC_STAGES+5]) begin
      rw_r <= rw_nxt;
    end
    if (en[SC_STAGES+6]) begin
      rot_r <= rot_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_tvalid   = v_r[NS-1];
  assign out_tdata    = {rot_r[2], rot_r[1], rot_r[0]};
  assign out_tuser[0] = sat_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> v_r == '0)
    else $error("pipeline valid bits not cleared by reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    v_r == '0 |-> in_tready)
    else $error("empty pipeline refuses input");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      rot_r[0] == COORD_MAX || rot_r[0] == COORD_MIN ||
      rot_r[1] == COORD_MAX || rot_r[1] == COORD_MIN ||
      rot_r[2] == COORD_MAX || rot_r[2] == COORD_MIN)
    else $error("saturated flag without a clipped coordinate");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[SC_STAGES-1] |->
      sin_v[0] <= TRIG_ONE && sin_v[0] >= -TRIG_ONE &&
      cos_v[1] <= TRIG_ONE && cos_v[1] >= -TRIG_ONE &&
      sin_v[2] <= TRIG_ONE && cos_v[2] >= -TRIG_ONE)
    else $error("trig value outside unit range");

endmodule

FILE: tb/tb_euler_point_rotation_3d_unit.sv
module tb_euler_point_rotation_3d_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import eprot_pkg::*;

  localparam int N_ENT = 256;
  localparam int TFB   = 15;

  typedef struct packed {
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
    logic signed [23:0] pz;
    logic signed [23:0] py;
    logic signed [23:0] px;
  } point_word_t;

  typedef struct {
    logic [23:0] rx;
    logic [23:0] ry;
    logic [23:0] rz;
    logic        sat;
  } rotated_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic [0:0]   out_tuser;

  euler_point_rotation_3d_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  point_word_t pending_words[$];
  rotated_t    expected_points[$];
  longint      sine_rom[0:N_ENT];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          mismatches;
  int          quiet_cycles;
  bit          timed_out;
  bit          in_accepted;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic longint rnd_shift(longint v, int s);
    longint w;
    w = v + (longint'(1) << (s - 1));
    return w >>> s;
  endfunction

  function automatic longint rom_entry(int i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          v;
    x    = longint'(i) * 64'd1686629713 / N_ENT;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int k = 1; k < 14; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    v = rnd_shift(acc, 30 - TFB);
    if (v < 0) v = 0;
    if (v > (longint'(1) << TFB)) v = longint'(1) << TFB;
    return v;
  endfunction

  function automatic longint sine_lookup(int u);
    int q;
    int idx;
    longint t;
    q   = (u / 5760) % 4;
    idx = (u % 5760) * N_ENT / 5760;
    t   = (q % 2 == 1) ? sine_rom[N_ENT - idx] : sine_rom[idx];
    return (q >= 2) ? -t : t;
  endfunction

  function automatic longint clip_coord(longint v, ref logic sat);
    if (v > 8388607) begin sat = 1'b1; return 8388607; end
    if (v < -8388608) begin sat = 1'b1; return -8388608; end
    return v;
  endfunction

  function automatic rotated_t rotate_point(point_word_t w);
    longint   s[3];
    longint   c[3];
    longint   p[3];
    longint   m[9];
    longint   sxsy;
    longint   cxsy;
    int       u;
    logic     sat;
    rotated_t r;
    logic signed [15:0] ang[3];
    ang[0] = w.ax; ang[1] = w.ay; ang[2] = w.az;
    p[0] = w.px; p[1] = w.py; p[2] = w.pz;
    for (int j = 0; j < 3; j++) begin
      u = int'(ang[j]) % 23040;
      if (u < 0) u += 23040;
      s[j] = sine_lookup(u);
      c[j] = sine_lookup((u + 5760) % 23040);
    end
    sxsy = rnd_shift(s[0] * s[1], TFB);
    cxsy = rnd_shift(c[0] * s[1], TFB);
    m[0] = rnd_shift(c[1] * c[2], TFB);
    m[1] = rnd_shift(c[1] * s[2], TFB);
    m[2] = -s[1];
    m[3] = rnd_shift(sxsy * c[2], TFB) - rnd_shift(c[0] * s[2], TFB);
    m[4] = rnd_shift(sxsy * s[2], TFB) + rnd_shift(c[0] * c[2], TFB);
    m[5] = rnd_shift(s[0] * c[1], TFB);
    m[6] = rnd_shift(cxsy * c[2], TFB) + rnd_shift(s[0] * s[2], TFB);
    m[7] = rnd_shift(cxsy * s[2], TFB) - rnd_shift(s[0] * c[2], TFB);
    m[8] = rnd_shift(c[0] * c[1], TFB);
    sat = 1'b0;
    r.rx = 24'(clip_coord(rnd_shift(p[0]*m[0] + p[1]*m[1] + p[2]*m[2], TFB), sat));
    r.ry = 24'(clip_coord(rnd_shift(p[0]*m[3] + p[1]*m[4] + p[2]*m[5], TFB), sat));
    r.rz = 24'(clip_coord(rnd_shift(p[0]*m[6] + p[1]*m[7] + p[2]*m[8], TFB), sat));
    r.sat = sat;
    return r;
  endfunction

  function automatic point_word_t random_word();
    point_word_t w;
    int shape;
    w = point_word_t'({$urandom, $urandom, $urandom, $urandom});
    shape = $urandom_range(0, 3);
    if (shape == 1) begin
      w.px = $signed(24'($urandom_range(0, 4095))) - 2048;
      w.py = $signed(24'($urandom_range(0, 4095))) - 2048;
      w.pz = $signed(24'($urandom_range(0, 4095))) - 2048;
    end else if (shape == 2) begin
      w.ax = 16'($urandom_range(0, 3) * 5760 + $urandom_range(0, 2) - 1);
      w.ay = 16'($urandom_range(0, 3) * 5760 + $urandom_range(0, 2) - 1);
      w.az = 16'($urandom_range(0, 3) * 5760 + $urandom_range(0, 2) - 1);
    end
    return w;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_accepted) void'(pending_words.pop_front());
      if (!in_tvalid || in_accepted) begin
        if (pending_words.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_words[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    rotated_t e;
    in_accepted <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_tvalid && in_tready) begin
        expected_points.push_back(rotate_point(point_word_t'(in_tdata)));
      end
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_tdata);
        end else begin
          e = expected_points.pop_front();
          if (out_tdata[23:0] !== e.rx || out_tdata[47:24] !== e.ry ||
              out_tdata[71:48] !== e.rz || out_tuser[0] !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h sat %b, got %h %h %h sat %b",
                       e.rx, e.ry, e.rz, e.sat, out_tdata[23:0], out_tdata[47:24],
                       out_tdata[71:48], out_tuser[0]);
          end
        end
      end
      if (quiet_cycles > 20000) timed_out = 1'b1;
    end
  end

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) pending_words.push_back(random_word());
    wait (pending_words.size() == 0 || timed_out);
  endtask

  initial begin
    point_word_t w;
    logic signed [23:0] pts[4];
    logic signed [15:0] angs[8];
    timed_out = 1'b0;
    in_accepted = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    for (int i = 0; i <= N_ENT; i++) sine_rom[i] = rom_entry(i);
    pts[0] = 24'sh7FFFFF; pts[1] = 24'sh800000; pts[2] = 24'sd256; pts[3] = 24'sd0;
    angs[0] = 16'sd0; angs[1] = 16'sd5760; angs[2] = 16'sd11520; angs[3] = 16'sd17280;
    angs[4] = 16'sh7FFF; angs[5] = 16'sh8000; angs[6] = -16'sd1; angs[7] = 16'sd23039;
    for (int i = 0; i < 8; i++) begin
      w.px = pts[i % 4]; w.py = pts[(i + 1) % 4]; w.pz = pts[(i + 2) % 4];
      w.ax = angs[i]; w.ay = angs[(i + 3) % 8]; w.az = angs[(i + 5) % 8];
      pending_words.push_back(w);
    end
    for (int i = 0; i < 8; i++) begin
      w.px = pts[i % 2]; w.py = pts[i % 2]; w.pz = pts[i % 2];
      w.ax = 16'sd2880; w.ay = 16'sd2880; w.az = angs[i];
      pending_words.push_back(w);
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_phase(0, 0, 230);
    run_phase(48, 0, 230);
    run_phase(0, 48, 230);
    run_phase(7, 7, 230);
    while ((expected_points.size() != 0 || in_tvalid) && !timed_out) @(posedge clk);
    repeat (40) @(posedge clk);
    if (timed_out) begin
      $display("== FAIL ==");
    end else if (mismatches == 0 && expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
